@@ rtl/balsm_pkg.sv @@
// ----------------------------------------------------------------------------
// balsm_pkg
// Types, sizes and access codes shared by the byte-addressed data memory.
// ----------------------------------------------------------------------------
`default_nettype none

package balsm_pkg;

  localparam int unsigned MEM_BYTES = 131072;
  localparam int unsigned ADDR_W    = $clog2(MEM_BYTES);
  localparam int unsigned NUM_BANKS = 4;
  localparam int unsigned ROWS      = MEM_BYTES / NUM_BANKS;
  localparam int unsigned ROW_W     = ADDR_W - 2;
  // one data byte plus its written flag
  localparam int unsigned ENTRY_W   = 9;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [ROW_W-1:0]   row_t;
  typedef logic [1:0]         lane_t;
  typedef logic [2:0]         kind_t;
  typedef logic [2:0]         nbytes_t;
  typedef logic [31:0]        word_t;
  typedef logic [ENTRY_W-1:0] entry_t;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_STORE = 1'b1;

  localparam kind_t KIND_BYTE  = 3'd0;
  localparam kind_t KIND_SBYTE = 3'd1;
  localparam kind_t KIND_HALF  = 3'd2;
  localparam kind_t KIND_SHALF = 3'd3;
  localparam kind_t KIND_WORD  = 3'd4;

  // bytes touched by an access kind, zero for unused codes
  function automatic nbytes_t kind_bytes(input kind_t kind);
    nbytes_t n;
    unique case (kind)
      KIND_BYTE, KIND_SBYTE: n = 3'd1;
      KIND_HALF, KIND_SHALF: n = 3'd2;
      KIND_WORD:             n = 3'd4;
      default:               n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

@@ rtl/balsm_if.sv @@
// ----------------------------------------------------------------------------
// balsm channel interfaces
// Valid/ready channels for requests into and load results out of the memory.
// ----------------------------------------------------------------------------
`default_nettype none

interface balsm_in_if;
  logic                   valid;
  logic                   ready;
  logic                   action;
  balsm_pkg::kind_t       access_kind;
  balsm_pkg::addr_t       address;
  balsm_pkg::word_t       store_data;

  modport source (output valid, output action, output access_kind,
                  output address, output store_data, input ready);
  modport sink   (input valid, input action, input access_kind,
                  input address, input store_data, output ready);
endinterface

interface balsm_out_if;
  logic                   valid;
  logic                   ready;
  balsm_pkg::word_t       load_data;

  modport source (output valid, output load_data, input ready);
  modport sink   (input valid, input load_data, output ready);
endinterface

`default_nettype wire

@@ rtl/balsm_ram.sv @@
// ----------------------------------------------------------------------------
// balsm_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module balsm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read data holds while the port is idle
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/byte_addressed_load_store_memory_top.sv @@
// ----------------------------------------------------------------------------
// byte_addressed_load_store_memory_top
// Little-endian byte-addressed data memory with byte, half and word access.
// ----------------------------------------------------------------------------
// The memory is four byte-wide banks, bank = address bits [1:0], each entry
// holding a data byte and its written flag, so any alignment is served by one
// access across the four banks. A request is taken every cycle while the result
// channel keeps up; a load result passes through the bank read registers, then
// the result register. When a result is held off, one more load waits in the
// bank read registers and in_ch.ready drops until the result moves.
// Stores produce no result. After reset a clearing pass walks all MEM_BYTES/4
// bank rows (32768 at the default size) with in_ch.ready low; loads that touch
// any byte never stored return 0, and addresses wrap modulo MEM_BYTES.
`default_nettype none

module byte_addressed_load_store_memory_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  balsm_in_if.sink   in_ch,
  balsm_out_if.source out_ch
);

  import balsm_pkg::*;

  logic    clr_busy_r, clr_busy_nxt;
  row_t    clr_row_r, clr_row_nxt;
  logic    pend_r, pend_nxt;
  kind_t   pend_kind_r;
  lane_t   pend_off_r;
  logic    out_valid_r, out_valid_nxt;
  word_t   out_data_r;

  logic    stall;
  logic    accept;
  logic    is_load;
  logic    store_ok;
  nbytes_t req_n;
  row_t    row_base;
  lane_t   req_off;

  logic    bank_en    [NUM_BANKS];
  logic    bank_we    [NUM_BANKS];
  row_t    bank_addr  [NUM_BANKS];
  entry_t  bank_wdata [NUM_BANKS];
  entry_t  bank_rdata [NUM_BANKS];

  word_t   load_val;

  // a finished load waits in the bank read registers while the output is full
  assign stall       = pend_r & out_valid_r & ~out_ch.ready;
  assign in_ch.ready = ~clr_busy_r & ~stall;
  assign accept      = in_ch.valid & in_ch.ready;
  assign is_load     = (in_ch.action == ACT_LOAD);
  assign req_n       = kind_bytes(in_ch.access_kind);
  assign store_ok    = (in_ch.access_kind != KIND_SBYTE) &&
                       (in_ch.access_kind != KIND_SHALF);
  assign row_base    = in_ch.address[ADDR_W-1:2];
  assign req_off     = in_ch.address[1:0];

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    lane_t lane_idx;
    word_t lane_data;

    // byte index of the access that lands in this bank
    assign lane_idx  = lane_t'(b) - req_off;
    assign lane_data = in_ch.store_data >> {lane_idx, 3'b000};

    always_comb begin
      if (clr_busy_r) begin
        bank_en[b]    = 1'b1;
        bank_we[b]    = 1'b1;
        bank_addr[b]  = clr_row_r;
        bank_wdata[b] = '0;
      end else begin
        bank_we[b]    = ~is_load & store_ok & ({1'b0, lane_idx} < req_n);
        bank_en[b]    = accept & (is_load | bank_we[b]);
        // banks below the start lane hold bytes of the next row
        bank_addr[b]  = row_base + ((lane_t'(b) < req_off) ? row_t'(1) : row_t'(0));
        bank_wdata[b] = {1'b1, lane_data[7:0]};
      end
    end

    balsm_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(ROWS)
    ) u_bank (
      .clk  (clk),
      .en   (bank_en[b]),
      .we   (bank_we[b]),
      .addr (bank_addr[b]),
      .wdata(bank_wdata[b]),
      .rdata(bank_rdata[b])
    );
  end

  // gather the bytes of a pending load and extend them
  always_comb begin
    lane_t   sel;
    nbytes_t n;
    logic    all_written;
    word_t   val;
    n           = kind_bytes(pend_kind_r);
    all_written = (n != 3'd0);
    val         = '0;
    for (int i = 0; i < NUM_BANKS; i++) begin
      sel = pend_off_r + lane_t'(i);
      if (nbytes_t'(i) < n) begin
        all_written     = all_written & bank_rdata[sel][8];
        val[8*i +: 8]   = bank_rdata[sel][7:0];
      end
    end
    if (pend_kind_r == KIND_SBYTE && val[7]) begin
      val[31:8] = '1;
    end
    if (pend_kind_r == KIND_SHALF && val[15]) begin
      val[31:16] = '1;
    end
    load_val = all_written ? val : '0;
  end

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_row_nxt  = clr_row_r;
    if (clr_busy_r) begin
      clr_row_nxt = clr_row_r + row_t'(1);
      if (clr_row_r == row_t'(ROWS - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
    pend_nxt      = (accept & is_load) | stall;
    out_valid_nxt = out_valid_r;
    if (pend_r & ~stall) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_row_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      clr_busy_r  <= clr_busy_nxt;
      clr_row_r   <= clr_row_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept & is_load) begin
      pend_kind_r <= in_ch.access_kind;
      pend_off_r  <= req_off;
    end
    if (pend_r & ~stall) begin
      out_data_r <= load_val;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.load_data = out_data_r;

endmodule

`default_nettype wire
